@@ sv/mkv_cluster_sync_search_core_macros.svh @@
// assertion macros shared by the search core
// clk and rst_n are taken from the module that uses them
`ifndef MKV_CLUSTER_SYNC_SEARCH_CORE_MACROS_SVH
`define MKV_CLUSTER_SYNC_SEARCH_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define MKV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MKV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MKV_ASSERT_IMP(lbl, ante, cons, msg)
`define MKV_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/mkv_pkg.sv @@
package mkv_pkg;

  localparam int WIN_LEN = 12;
  localparam int OFS_W   = 48;
  // highest window position that can still hold a whole start
  localparam int POS_MAX = 7;
  localparam int POS_N   = POS_MAX + 1;

  localparam logic [0:3][7:0] CLUSTER_ID = {8'h1f, 8'h43, 8'hb6, 8'h75};
  localparam logic [7:0]      SIZE_TAG   = 8'he7;

  // index 0 is the oldest byte, index WIN_LEN the byte just taken
  typedef logic [0:WIN_LEN][7:0] seq_t;

  typedef struct packed {
    logic             valid;
    seq_t             seq;
    logic [OFS_W-1:0] count;
    logic [3:0]       avail;
    logic             last;
  } stage_t;

endpackage

@@ sv/mkv_if.sv @@
interface mkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mkv_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [47:0] offset;

  modport source (output valid, found, offset, input ready);
  modport sink   (input valid, found, offset, output ready);
endinterface

@@ sv/mkv_match.sv @@
module mkv_match (
  input  mkv_pkg::seq_t             seq,
  output logic [mkv_pkg::POS_N-1:0] match
);
  import mkv_pkg::*;

  // a start at position j needs the id, a nonzero size byte, and the tag
  // right after the size field, all inside the window
  always_comb begin
    for (int j = 0; j < POS_N; j++) begin
      logic id_ok;
      logic tag_ok;
      id_ok  = (seq[j] == CLUSTER_ID[0]) && (seq[j+1] == CLUSTER_ID[1]) &&
               (seq[j+2] == CLUSTER_ID[2]) && (seq[j+3] == CLUSTER_ID[3]);
      tag_ok = 1'b0;
      for (int k = 1; k <= 8; k++) begin
        if (j + 4 + k <= WIN_LEN) begin
          if (((seq[j+4] >> (8 - k)) == 8'd1) && (seq[j+4+k] == SIZE_TAG)) begin
            tag_ok = 1'b1;
          end
        end
      end
      match[j] = id_ok && tag_ok;
    end
  end

endmodule

@@ sv/mkv_front.sv @@
module mkv_front (
  input  logic            clk,
  input  logic            rst_n,
  mkv_in_if.sink          in_chan,
  input  logic            retire,
  output mkv_pkg::stage_t stage
);
  import mkv_pkg::*;

  logic [7:0]       win_r [WIN_LEN];
  logic [OFS_W-1:0] count_r;
  logic [OFS_W-1:0] count_nxt;
  logic [3:0]       avail;
  stage_t           stage_r;
  logic             take;

  assign in_chan.ready = !stage_r.valid || retire;
  assign take          = in_chan.valid && in_chan.ready;
  assign stage         = stage_r;

  assign avail     = (count_r >= OFS_W'(WIN_LEN)) ? 4'(WIN_LEN) : count_r[3:0];
  assign count_nxt = (count_r == {OFS_W{1'b1}}) ? count_r : count_r + OFS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (take) begin
      if (in_chan.last_byte) begin
        count_r <= '0;
        for (int i = 0; i < WIN_LEN; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        count_r <= count_nxt;
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WIN_LEN-1] <= in_chan.data_byte;
      end
    end
  end

  // only the valid flag is reset, the payload loads on every transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (take) begin
      stage_r.valid <= 1'b1;
    end else if (retire) begin
      stage_r.valid <= 1'b0;
    end
    if (take) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        stage_r.seq[i] <= win_r[i];
      end
      stage_r.seq[WIN_LEN] <= in_chan.data_byte;
      stage_r.count        <= count_r;
      stage_r.avail        <= avail;
      stage_r.last         <= in_chan.last_byte;
    end
  end

endmodule

@@ sv/mkv_cluster_sync_search_core.sv @@
// cluster sync search core
// in_chan takes one file byte per transfer, last_byte marks the end of
// the searched range. out_chan gives at most one result per search:
// found=1 with the absolute offset of the lowest cluster start, or, on
// the last byte, found=0 and offset 0 when nothing matched.
// cfg_we/cfg_wdata load base_offset, the file position of the first
// byte; write it only while the block is idle.
// the byte that completes a result loads the input register at its
// transfer; the result then loads the result register, which drives out_chan.
// throughput: one byte per cycle while no result waits on a stalled
// out_chan, set by the single pass from the stage register through the
// 13-byte compare, priority pick and offset add. a byte with no result
// retires even while out_chan is stalled; a byte with a result waits in
// the stage register, and in_chan ready drops only then. reset clears the
// window, byte count, reported flag, base_offset and both valid flags;
// after the last byte the search state clears.
`include "mkv_cluster_sync_search_core_macros.svh"

module mkv_cluster_sync_search_core (
  input  logic                      clk,
  input  logic                      rst_n,
  mkv_in_if.sink                    in_chan,
  mkv_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [mkv_pkg::OFS_W-1:0] cfg_wdata
);
  import mkv_pkg::*;

  stage_t           s1;
  logic [POS_N-1:0] match;
  logic [POS_N-1:0] cand;
  logic             hit;
  logic [2:0]       sel;
  logic             produce;
  logic             advance;
  logic             retire;

  logic [OFS_W-1:0] base_r;
  logic             reported_r;
  logic             out_v_r;
  logic             out_v_nxt;
  logic             found_r;
  logic [OFS_W-1:0] offset_r;
  logic [OFS_W-1:0] offset_nxt;

  // window, byte count and input register
  mkv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .retire  (retire),
    .stage   (s1)
  );

  // start detectors for window positions 0 to POS_MAX
  mkv_match u_match (
    .seq   (s1.seq),
    .match (match)
  );

  // a position counts only if it holds a real byte; before the last byte
  // only the oldest position of a full window is tested
  always_comb begin
    for (int j = 0; j < POS_N; j++) begin
      cand[j] = match[j] && ((5'(j) + {1'b0, s1.avail}) >= 5'(WIN_LEN)) &&
                (s1.last || (j == 0));
    end
  end

  // lowest position wins
  always_comb begin
    sel = '0;
    for (int j = POS_N - 1; j >= 0; j--) begin
      if (cand[j]) begin
        sel = 3'(j);
      end
    end
  end

  assign hit = |cand;

  // stream index of position sel is count + sel - 12, wrapped
  assign offset_nxt = base_r + s1.count + OFS_W'(sel) - OFS_W'(WIN_LEN);

  assign produce = s1.valid && !reported_r && (hit || s1.last);
  assign advance = !out_v_r || out_chan.ready;
  assign retire  = s1.valid && (!produce || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // reported blocks later hits until the end of the search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r <= 1'b0;
    end else if (retire) begin
      if (s1.last) begin
        reported_r <= 1'b0;
      end else if (produce) begin
        reported_r <= 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    out_v_nxt = out_v_r && !out_chan.ready;
    if (produce && advance) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && advance) begin
      found_r  <= hit;
      offset_r <= hit ? offset_nxt : '0;
    end
  end

  assign out_chan.valid  = out_v_r;
  assign out_chan.found  = found_r;
  assign out_chan.offset = offset_r;

  `MKV_ASSERT_NXT(a_clear_after_last, retire && s1.last, !reported_r,
                  "reported flag survived the end of a search")
  `MKV_ASSERT_IMP(a_one_per_search, reported_r && s1.valid, !produce,
                  "second result in one search")
  `MKV_ASSERT_IMP(a_stall_cause, !in_chan.ready, s1.valid && out_v_r && produce,
                  "input stalled without a waiting result")

endmodule
